// ----- rtl/adm_pkg.sv -----
// ----------------------------------------------------------------------------
// adm_pkg: shared types and constants
// byte codes, escape phase type, queue command format and the coordinate
// digit helper used by the terminal output translator
// ----------------------------------------------------------------------------
package adm_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_VT    = 8'h0B;
    localparam logic [7:0] C_FF    = 8'h0C;
    localparam logic [7:0] C_SUB   = 8'h1A;
    localparam logic [7:0] C_ESC   = 8'h1B;
    localparam logic [7:0] C_RS    = 8'h1E;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_DEL   = 8'h7F;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_LBRK  = 8'h5B;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_UP    = 8'h41;
    localparam logic [7:0] C_RIGHT = 8'h43;
    localparam logic [7:0] C_HOME  = 8'h48;
    localparam logic [7:0] C_TWO   = 8'h32;
    localparam logic [7:0] C_ERASE = 8'h4A;
    localparam logic [7:0] C_CUR   = 8'hA4;
    localparam logic [7:0] C_COPY  = 8'hA9;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_OFS   = 8'd31;
    localparam logic [7:0] C_TWO_DIGIT_MIN = 8'd41;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_ROW  = 3'd2,
        PH_COL  = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_CSI    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_CURSOR = 2'd3
    } t_op;

    typedef struct packed {
        logic       two;
        logic [7:0] hi;
        logic [7:0] lo;
    } t_coord;

    typedef struct packed {
        t_op        op;
        logic [7:0] arg;
        t_coord     row;
        t_coord     col;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_coord coord_digits(input logic [7:0] v);
        t_coord     c;
        logic [7:0] d;
        logic [15:0] prod;
        logic [4:0] q;
        logic [7:0] q10;
        logic [7:0] rem;
        d    = v - C_OFS;
        prod = {8'd0, d} * 16'd205;
        q    = prod[15:11];
        q10  = {q, 3'b000} + {2'b00, q, 1'b0};
        rem  = d - q10;
        c.two = (v >= C_TWO_DIGIT_MIN);
        if (c.two) begin
            c.hi = C_ZERO + {3'b000, q};
            c.lo = C_ZERO + rem;
        end else begin
            c.hi = C_ZERO;
            c.lo = d + C_ZERO;
        end
        return c;
    endfunction

endpackage

// ----- rtl/adm3a_to_ansi_output_translator_unit.sv -----
// ----------------------------------------------------------------------------
// adm3a_to_ansi_output_translator_unit: terminal output translator
// A new input byte is taken in every cycle while the command queue
// (QUEUE_DEPTH entries) has room; bytes that only change escape state or
// produce nothing push no command. Results leave one byte per cycle from
// the byte sequencer while the output is not stalled. An input yields
// 1 byte for a plain byte, 3 for a cursor key, 7 for clear screen and
// 6 to 8 for cursor addressing. The sustained rate is set by that sequencer.
// Cursor addressing "ESC = row col" becomes ESC [ r ; c H, the final byte of
// each input's result carrying the last flag.
// ----------------------------------------------------------------------------
module adm3a_to_ansi_output_translator_unit
    import adm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic      accept;
    logic      push;
    logic      pop;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    t_phase    phase;

    assign o_stall = q_status.full;
    assign accept  = i_valid && !q_status.full;

    adm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .o_phase   (phase)
    );

    adm_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    adm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_empty    (q_status.empty),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

`ifndef NO_ASSERTIONS
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_nul_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_byte == C_NUL && (phase == PH_IDLE || phase == PH_ESC))
        |-> !push)
        else $error("zero byte produced output");
`endif

endmodule

// ----- rtl/adm_front.sv -----
// ----------------------------------------------------------------------------
// adm_front: escape tracker and classifier
// follows the escape phase and held row, turns each input beat into at most
// one command for the byte sequencer
// ----------------------------------------------------------------------------
module adm_front
    import adm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    output logic       o_push,
    output t_cmd       o_cmd,
    output t_phase     o_phase
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held_row, n_held_row;
    t_phase     base;
    logic       has_out;
    logic       printable;

    assign printable = (i_in_byte >= C_SPACE) && (i_in_byte < C_DEL);

    always_comb begin
        base = (r_phase == PH_ESC) ? PH_ESC : PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_held_row <= 8'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_held_row <= n_held_row;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_held_row = r_held_row;
        unique case (r_phase)
            PH_ROW: begin
                n_held_row = i_in_byte;
                n_phase    = PH_COL;
            end
            PH_COL: begin
                n_phase = PH_DONE;
            end
            default: begin
                if (r_phase == PH_DONE && i_in_byte == C_EQ) begin
                    n_phase = PH_ROW;
                end else if (i_in_byte == C_ESC) begin
                    n_phase = (base == PH_IDLE) ? PH_ESC : PH_IDLE;
                end else if (i_in_byte == C_EQ) begin
                    n_phase = (base == PH_ESC) ? PH_ROW : PH_IDLE;
                end else begin
                    n_phase = base;
                end
            end
        endcase
    end

    always_comb begin
        has_out   = 1'b0;
        o_cmd.op  = OP_BYTE;
        o_cmd.arg = i_in_byte;
        o_cmd.row = coord_digits(r_held_row);
        o_cmd.col = coord_digits(i_in_byte);
        unique case (r_phase)
            PH_ROW: begin
                has_out = 1'b0;
            end
            PH_COL: begin
                has_out  = 1'b1;
                o_cmd.op = OP_CURSOR;
            end
            default: begin
                if (r_phase == PH_DONE && i_in_byte == C_EQ) begin
                    has_out = 1'b0;
                end else if (printable && base == PH_IDLE) begin
                    has_out = 1'b1;
                end else begin
                    unique case (i_in_byte)
                        C_VT: begin
                            has_out   = 1'b1;
                            o_cmd.op  = OP_CSI;
                            o_cmd.arg = C_UP;
                        end
                        C_FF: begin
                            has_out   = 1'b1;
                            o_cmd.op  = OP_CSI;
                            o_cmd.arg = C_RIGHT;
                        end
                        C_RS: begin
                            has_out   = 1'b1;
                            o_cmd.op  = OP_CSI;
                            o_cmd.arg = C_HOME;
                        end
                        C_SUB: begin
                            has_out  = 1'b1;
                            o_cmd.op = OP_CLEAR;
                        end
                        C_ESC: begin
                            has_out = 1'b0;
                        end
                        C_EQ: begin
                            has_out = (base != PH_ESC);
                        end
                        C_CUR: begin
                            has_out   = 1'b1;
                            o_cmd.arg = C_COPY;
                        end
                        C_NUL: begin
                            has_out = 1'b0;
                        end
                        default: begin
                            has_out = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    assign o_push  = i_accept && has_out;
    assign o_phase = r_phase;

endmodule

// ----- rtl/adm_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// adm_cmd_queue: command queue
// small first-in first-out store between classifier and byte sequencer
// ----------------------------------------------------------------------------
module adm_cmd_queue
    import adm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);

endmodule

// ----- rtl/adm_back.sv -----
// ----------------------------------------------------------------------------
// adm_back: byte sequencer
// expands the head command into its ansi byte sequence, one byte per beat,
// through a registered output stage
// ----------------------------------------------------------------------------
module adm_back
    import adm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_empty,
    input  logic       i_stall,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic [7:0] seq [8];
    logic [3:0] len;
    logic [2:0] p;
    logic [2:0] r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       issue;
    logic       at_end;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            seq[k] = C_HOME;
        end
        p   = 3'd3;
        len = 4'd1;
        seq[0] = C_ESC;
        seq[1] = C_LBRK;
        case (i_cmd.op)
            OP_BYTE: begin
                seq[0] = i_cmd.arg;
                len    = 4'd1;
            end
            OP_CSI: begin
                seq[2] = i_cmd.arg;
                len    = 4'd3;
            end
            OP_CLEAR: begin
                seq[2] = C_TWO;
                seq[3] = C_ERASE;
                seq[4] = C_ESC;
                seq[5] = C_LBRK;
                seq[6] = C_HOME;
                len    = 4'd7;
            end
            default: begin
                if (i_cmd.row.two) begin
                    seq[2] = i_cmd.row.hi;
                    seq[3] = i_cmd.row.lo;
                    p      = 3'd4;
                end else begin
                    seq[2] = i_cmd.row.lo;
                    p      = 3'd3;
                end
                seq[p] = C_SEMI;
                if (i_cmd.col.two) begin
                    seq[3'(p + 3'd1)] = i_cmd.col.hi;
                    seq[3'(p + 3'd2)] = i_cmd.col.lo;
                    seq[3'(p + 3'd3)] = C_HOME;
                    len = {1'b0, p} + 4'd4;
                end else begin
                    seq[3'(p + 3'd1)] = i_cmd.col.lo;
                    seq[3'(p + 3'd2)] = C_HOME;
                    len = {1'b0, p} + 4'd3;
                end
            end
        endcase
    end

    assign issue  = !i_empty && (!r_valid || !i_stall);
    assign at_end = ({1'b0, r_step} == (len - 4'd1));
    assign o_pop  = issue && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 3'd0;
        end else begin
            if (issue) begin
                r_valid <= 1'b1;
                r_step  <= at_end ? 3'd0 : r_step + 3'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_byte <= seq[r_step];
            r_last <= at_end;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule
